/* hdl/sfe_pkg.sv */
package sfe_pkg;

    localparam logic [7:0] CH_START  = 8'h23;
    localparam logic [7:0] CH_ADDR   = 8'h61;
    localparam logic [7:0] CH_OFFSET = 8'h3D;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_DATA  = 2'd1,
        OP_END   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        PH_HDR = 3'b001,
        PH_GRP = 3'b010,
        PH_SUM = 3'b100
    } phase_t;

    // One queued job for the back end. A header job carries address and
    // command id in b0 and b1; a group job carries the three group bytes.
    typedef struct packed {
        logic       has_hdr;
        logic       has_grp;
        logic       has_sum;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } cmd_t;

endpackage

/* hdl/sfe_front.sv */
module sfe_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic [7:0]         address,
    input  logic [7:0]         cmd_id,
    input  logic [7:0]         data_byte,
    input  logic               q_full,
    output logic               push,
    output sfe_pkg::cmd_t      push_cmd
);

    logic [1:0] fill_reg, fill_next;
    logic [7:0] g0_reg, g0_next;
    logic [7:0] g1_reg, g1_next;
    logic       accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        fill_next = fill_reg;
        g0_next   = g0_reg;
        g1_next   = g1_reg;
        push      = 1'b0;
        push_cmd  = '0;
        if (accept)
        begin
            case (op)
                sfe_pkg::OP_START:
                begin
                    push             = 1'b1;
                    push_cmd.has_hdr = 1'b1;
                    push_cmd.b0      = address;
                    push_cmd.b1      = cmd_id;
                    fill_next        = 2'd0;
                    g0_next          = 8'd0;
                    g1_next          = 8'd0;
                end
                sfe_pkg::OP_DATA:
                begin
                    if (fill_reg >= 2'd2)
                    begin
                        push             = 1'b1;
                        push_cmd.has_grp = 1'b1;
                        push_cmd.b0      = g0_reg;
                        push_cmd.b1      = g1_reg;
                        push_cmd.b2      = data_byte;
                        fill_next        = 2'd0;
                        g0_next          = 8'd0;
                        g1_next          = 8'd0;
                    end
                    else
                    begin
                        if (fill_reg[0])
                            g1_next = data_byte;
                        else
                            g0_next = data_byte;
                        fill_next = fill_reg + 2'd1;
                    end
                end
                sfe_pkg::OP_END:
                begin
                    push             = 1'b1;
                    push_cmd.has_sum = 1'b1;
                    push_cmd.has_grp = (fill_reg != 2'd0);
                    push_cmd.b0      = g0_reg;
                    push_cmd.b1      = (fill_reg >= 2'd2) ? g1_reg : 8'd0;
                    push_cmd.b2      = 8'd0;
                    fill_next        = 2'd0;
                    g0_next          = 8'd0;
                    g1_next          = 8'd0;
                end
                default:
                begin
                    // Unused op code: dropped without effect.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 2'd0;
            g0_reg   <= 8'd0;
            g1_reg   <= 8'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            g0_reg   <= g0_next;
            g1_reg   <= g1_next;
        end
    end

endmodule

/* hdl/sfe_queue.sv */
module sfe_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sfe_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output sfe_pkg::cmd_t head
);

    sfe_pkg::cmd_t                  mem_reg [sfe_pkg::QDEPTH];
    logic [sfe_pkg::QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [sfe_pkg::QCNT_W-1:0]     count_reg;
    logic                           do_push, do_pop;

    assign full       = (count_reg == sfe_pkg::QCNT_W'(sfe_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == sfe_pkg::QPTR_W'(sfe_pkg::QDEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == sfe_pkg::QPTR_W'(sfe_pkg::QDEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* hdl/sfe_back.sv */
module sfe_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  sfe_pkg::cmd_t head,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_char,
    output logic          out_last
);

    sfe_pkg::phase_t phase_reg, phase_next, phase;
    logic            start_reg, start_next;
    logic [1:0]      idx_reg, idx_next;
    logic [11:0]     sum_reg, sum_next;
    logic            valid_reg;
    logic [7:0]      char_reg;
    logic            last_reg;
    logic            load;
    logic [7:0]      ch;
    logic [5:0]      slice;
    logic            is_last, end_step;

    // At the first step of a job the phase comes from the job itself.
    always_comb
    begin
        if (!start_reg)
            phase = phase_reg;
        else if (head.has_hdr)
            phase = sfe_pkg::PH_HDR;
        else if (head.has_grp)
            phase = sfe_pkg::PH_GRP;
        else
            phase = sfe_pkg::PH_SUM;
    end

    assign load = head_valid && (!valid_reg || out_ready);

    always_comb
    begin
        case (idx_reg)
            2'd0:    slice = head.b0[7:2];
            2'd1:    slice = {head.b0[1:0], head.b1[7:4]};
            2'd2:    slice = {head.b1[3:0], head.b2[7:6]};
            default: slice = head.b2[5:0];
        endcase
    end

    always_comb
    begin
        ch       = sfe_pkg::CH_CR;
        is_last  = 1'b0;
        end_step = 1'b0;
        unique case (phase)
            sfe_pkg::PH_HDR:
            begin
                end_step = (idx_reg == 2'd2);
                case (idx_reg)
                    2'd0:    ch = sfe_pkg::CH_START;
                    2'd1:    ch = head.b0 + sfe_pkg::CH_ADDR;
                    default: ch = head.b1;
                endcase
            end
            sfe_pkg::PH_GRP:
            begin
                end_step = (idx_reg == 2'd3);
                ch       = sfe_pkg::CH_OFFSET + {2'b00, slice};
            end
            sfe_pkg::PH_SUM:
            begin
                end_step = (idx_reg == 2'd2);
                is_last  = (idx_reg == 2'd2);
                case (idx_reg)
                    2'd0:    ch = sfe_pkg::CH_OFFSET + {2'b00, sum_reg[11:6]};
                    2'd1:    ch = sfe_pkg::CH_OFFSET + {2'b00, sum_reg[5:0]};
                    default: ch = sfe_pkg::CH_CR;
                endcase
            end
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        start_next = start_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        pop        = 1'b0;
        if (load)
        begin
            if (phase == sfe_pkg::PH_HDR && idx_reg == 2'd0)
                sum_next = {4'd0, ch};
            else if (phase != sfe_pkg::PH_SUM)
                sum_next = sum_reg + {4'd0, ch};
            else if (is_last)
                sum_next = 12'd0;

            if (!end_step)
            begin
                phase_next = phase;
                start_next = 1'b0;
                idx_next   = idx_reg + 2'd1;
            end
            else if (phase == sfe_pkg::PH_GRP && head.has_sum)
            begin
                phase_next = sfe_pkg::PH_SUM;
                start_next = 1'b0;
                idx_next   = 2'd0;
            end
            else
            begin
                pop        = 1'b1;
                start_next = 1'b1;
                idx_next   = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sfe_pkg::PH_HDR;
            start_reg <= 1'b1;
            idx_reg   <= 2'd0;
            sum_reg   <= 12'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            start_reg <= start_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
            if (load)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= ch;
            last_reg <= is_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

/* hdl/serial_frame_encoder.sv */
// Channel  Dir  tdata (low bit up)                tuser     tlast
// s_axis   in   address, cmd_id, data_byte (24b)  op (2b)   -
// m_axis   out  out_char (8b)                     -         last
//
// Each request is classified combinationally and queued; the queue takes a
// new request every cycle while it has room (two entries).
// Unless the output stalls, the character unit sends one character per cycle:
// start 3, completing payload byte 4, end 3 or 7; it sets the sustained rate.
// Reset clears the group buffer, the checksum, the queue and the output valid.
// A stalled output holds its character; the queue keeps accepting until full.
module serial_frame_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // address, cmd_id, data_byte
    input  logic [1:0]  s_tuser,  // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // out_char
    output logic        m_tlast
);

    logic          push, q_full, pop, head_valid;
    sfe_pkg::cmd_t push_cmd, head;

    sfe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .op        (s_tuser),
        .address   (s_tdata[7:0]),
        .cmd_id    (s_tdata[15:8]),
        .data_byte (s_tdata[23:16]),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    sfe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    sfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_char   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule

/* hdl/sfe_checker.sv */
module sfe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    a_idle_in_reset: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("output valid during reset");

    a_ready_after_reset: assert property (@(posedge clk) $rose(rst_n) |-> s_tready)
        else $error("input not ready after reset");

    a_request_held: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("waiting request changed");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output changed");

    a_last_is_cr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata == sfe_pkg::CH_CR)
        else $error("frame end is not a carriage return");

endmodule

bind serial_frame_encoder sfe_checker u_sfe_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
